// ----- rtl/core/vra_pkg.sv -----
`default_nettype none

package vra_pkg;

   localparam int PAGE_BYTES          = 4096;
   localparam int PAGE_SHIFT          = $clog2(PAGE_BYTES);
   localparam int MAX_REGIONS_DEFAULT = 64;
   localparam int FREE_PAGES_W        = 21;

   localparam logic [31:0] ONE_PAGE    = 32'(PAGE_BYTES);
   localparam logic [31:0] PAGE_ROUND  = 32'(PAGE_BYTES - 1);
   localparam logic [31:0] PAGE_MASK   = ~PAGE_ROUND;

   localparam logic [1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_CHECK   = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic REG_POOL_BASE = 1'b0;
   localparam logic REG_POOL_SIZE = 1'b1;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] request_size;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [31:0]             region_address;
      logic [31:0]             free_start;
      logic [FREE_PAGES_W-1:0] free_pages;
      logic                    legitimate;
   } rsp_type;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] size;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic wrap;
      logic load;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/vra_cell.sv -----
`default_nettype none

module vra_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  wire logic                  clock,
   input  wire vra_pkg::cell_ctrl_type ctrl,
   input  wire logic [CNT_W-1:0]      pos,
   input  wire vra_pkg::entry_type    head_entry,
   input  wire vra_pkg::entry_type    next_entry,
   input  wire vra_pkg::entry_type    load_entry,
   output vra_pkg::entry_type         entry
);
   import vra_pkg::*;

   localparam logic [CNT_W-1:0] POS_SELF = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(INDEX + 1);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load && (pos == POS_SELF)) begin
         entry_in = load_entry;
      end else if (ctrl.shift && (POS_NEXT < pos)) begin
         entry_in = next_entry;
      end else if (ctrl.wrap && (POS_NEXT == pos)) begin
         entry_in = head_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/core/virtual_region_allocator_top.sv -----
// channel   ports                                   direction  transfer when
// request   start, busy, req_item                   in         start && !busy
// result    rsp_valid, rsp_item                     out        rsp_valid
// config    psel, penable, pwrite, paddr, pwdata,   in         psel && penable && pwrite
//           prdata, pready
//
// allocate, check, unknown codes and a release with no live regions: the result shows
// the cycle after; another release rotates the region ring once, a step per live
// region (up to MAX_REGIONS), then the result shows; busy is high during the rotation
// reset is synchronous and loads entry 0 with one page at pool base 0
// the result strobe lasts one cycle and cannot be stalled
`default_nettype none

module virtual_region_allocator_top #(
   parameter int MAX_REGIONS = vra_pkg::MAX_REGIONS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire vra_pkg::req_type req_item,
   output logic             rsp_valid,
   output vra_pkg::rsp_type rsp_item,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import vra_pkg::*;

   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_ROTATE = 1'b1;

   logic              state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic              found_ff, found_in;
   logic [31:0]       addr_ff, addr_in;
   logic [FREE_PAGES_W-1:0] pages_ff, pages_in;
   entry_type         last_ff, last_in;
   logic [31:0]       pool_base_ff, pool_base_in;
   logic [31:0]       pool_size_ff, pool_size_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   cell_ctrl_type     ctrl;
   logic [CNT_W-1:0]  load_pos;
   logic [CNT_W-1:0]  cell_pos;
   entry_type         load_entry;
   entry_type         cell_entry [MAX_REGIONS];
   entry_type         head;

   logic              accept;
   logic              cfg_wr;
   logic              base_wr;
   logic              hit;
   logic              found_now;
   logic [CNT_W-1:0]  step_next;
   logic [31:0]       alloc_size;
   logic [31:0]       alloc_base;
   logic [32:0]       pool_hi;
   logic [31:0]       head_pages;

   assign pready  = 1'b1;
   assign busy    = (state_ff == ST_ROTATE);
   assign accept  = start && !busy;
   assign cfg_wr  = psel && penable && pwrite;
   assign base_wr = cfg_wr && (paddr[2] == REG_POOL_BASE);
   assign prdata  = (paddr[2] == REG_POOL_BASE) ? pool_base_ff : pool_size_ff;

   assign head       = cell_entry[0];
   assign hit        = !found_ff && (head.base == addr_ff);
   assign found_now  = found_ff || hit;
   assign step_next  = step_ff + 1'b1;
   assign head_pages = head.size >> PAGE_SHIFT;
   assign alloc_size = (req_item.request_size + PAGE_ROUND) & PAGE_MASK;
   assign alloc_base = (count_ff == '0) ? pool_base_ff : (last_ff.base + last_ff.size);
   assign pool_hi    = {1'b0, pool_base_ff} + {1'b0, pool_size_ff};
   assign cell_pos   = ctrl.load ? load_pos : len_ff;

   always_comb begin
      pool_base_in = pool_base_ff;
      pool_size_in = pool_size_ff;
      if (cfg_wr) begin
         if (paddr[2] == REG_POOL_BASE) begin
            pool_base_in = pwdata;
         end else begin
            pool_size_in = pwdata;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      addr_in      = addr_ff;
      pages_in     = pages_ff;
      last_in      = last_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      ctrl         = '0;
      load_pos     = '0;
      load_entry   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.func)
                  FUNC_ALLOC: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_MAX) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        ctrl.load             = 1'b1;
                        load_pos              = count_ff;
                        load_entry.base       = alloc_base;
                        load_entry.size       = alloc_size;
                        last_in               = load_entry;
                        count_in              = count_ff + 1'b1;
                        rsp_in.region_address = alloc_base;
                     end
                  end
                  FUNC_RELEASE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_NOT_FOUND;
                     end else begin
                        state_in = ST_ROTATE;
                        len_in   = count_ff;
                        step_in  = '0;
                        found_in = 1'b0;
                        addr_in  = req_item.address;
                     end
                  end
                  FUNC_CHECK: begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.legitimate = (req_item.address >= pool_base_ff)
                                         && ({1'b0, req_item.address} <= pool_hi);
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ROTATE: begin
            ctrl.shift = 1'b1;
            if (hit) begin
               len_in   = len_ff - 1'b1;
               found_in = 1'b1;
               pages_in = head_pages[FREE_PAGES_W-1:0];
            end else begin
               ctrl.wrap = 1'b1;
               last_in   = head;
            end
            step_in = step_next;
            if (step_next == count_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (found_now) begin
                  count_in          = count_ff - 1'b1;
                  rsp_in.free_start = addr_ff;
                  rsp_in.free_pages = hit ? head_pages[FREE_PAGES_W-1:0] : pages_ff;
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // table init on reset or pool base write
      if (reset || base_wr) begin
         ctrl            = '0;
         ctrl.load       = 1'b1;
         load_pos        = '0;
         load_entry.base = reset ? 32'd0 : pwdata;
         load_entry.size = ONE_PAGE;
         last_in         = load_entry;
         count_in        = CNT_W'(1);
      end
   end

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      entry_type next_entry;
      if (i == MAX_REGIONS - 1) begin : g_end
         assign next_entry = head;
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end
      vra_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (cell_pos),
         .head_entry (head),
         .next_entry (next_entry),
         .load_entry (load_entry),
         .entry      (cell_entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(1);
         len_ff       <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         last_ff      <= '{base: 32'd0, size: ONE_PAGE};
         pool_base_ff <= '0;
         pool_size_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         last_ff      <= last_in;
         pool_base_ff <= pool_base_in;
         pool_size_ff <= pool_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      pages_ff <= pages_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_release_rotates: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.func == FUNC_RELEASE) && (count_ff != '0)) |=> busy)
      else $error("release with live regions did not start a rotation");

   a_rotate_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROTATE) && (step_next == count_ff)) |=> (rsp_valid && !busy))
      else $error("rotation finished without a result");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == STATUS_FULL)) |-> (count_ff == CNT_MAX))
      else $error("table full reported below capacity");

   a_ring_len_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |-> ((len_ff <= count_ff) && (step_ff < count_ff)))
      else $error("ring length or step beyond region count");

endmodule

`default_nettype wire

// ----- sim/virtual_region_allocator_top_test.sv -----
`default_nettype none

module virtual_region_allocator_top_test;
   import vra_pkg::*;

   localparam int REGIONS = MAX_REGIONS_DEFAULT;
   localparam int SETTLE = REGIONS + 8;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [2:0] ADDR_POOL_BASE = {REG_POOL_BASE, 2'b00};
   localparam logic [2:0] ADDR_POOL_SIZE = {REG_POOL_SIZE, 2'b00};

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic [31:0] pool_base_q;
   logic [31:0] pool_size_q;
   logic [31:0] region_base_q [REGIONS];
   logic [31:0] region_size_q [REGIONS];
   int unsigned region_total;
   rsp_type     expected_rsps [$];
   int          errors;
   bit          quiet;

   // typed rows follow from reset values: pool base 0, pool size 0
   stim_row_type directed_rows [25] = '{
      '{'{FUNC_CHECK, 32'h0, 32'h0}, 1'b1, '{STATUS_OK, 32'h0, 32'h0, 21'h0, 1'b1}},
      '{'{FUNC_CHECK, 32'h0, 32'h1}, 1'b1, '{STATUS_OK, 32'h0, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_CHECK, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
        '{STATUS_OK, 32'h0, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_ALLOC, 32'h0, 32'h0}, 1'b1, '{STATUS_OK, 32'h1000, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_ALLOC, 32'h1, 32'hFFFFFFFF}, 1'b1,
        '{STATUS_OK, 32'h1000, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_ALLOC, 32'h1000, 32'h0}, 1'b1, '{STATUS_OK, 32'h2000, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_ALLOC, 32'h1001, 32'h0}, 1'b1, '{STATUS_OK, 32'h3000, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_ALLOC, 32'hFFFFFFFF, 32'h0}, 1'b1,
        '{STATUS_OK, 32'h5000, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_ALLOC, 32'hFFFFF000, 32'h0}, 1'b1,
        '{STATUS_OK, 32'h5000, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_ALLOC, 32'h5, 32'h0}, 1'b0, '0},
      '{'{FUNC_RELEASE, 32'h0, 32'h1000}, 1'b1,
        '{STATUS_OK, 32'h0, 32'h1000, 21'h0, 1'b0}},
      '{'{FUNC_RELEASE, 32'h0, 32'h1000}, 1'b1,
        '{STATUS_OK, 32'h0, 32'h1000, 21'h1, 1'b0}},
      '{'{FUNC_RELEASE, 32'h0, 32'h1000}, 1'b1,
        '{STATUS_NOT_FOUND, 32'h0, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_RELEASE, 32'hFFFFFFFF, 32'h0}, 1'b1,
        '{STATUS_OK, 32'h0, 32'h0, 21'h1, 1'b0}},
      '{'{FUNC_RELEASE, 32'h0, 32'h5000}, 1'b1,
        '{STATUS_OK, 32'h0, 32'h5000, 21'h0, 1'b0}},
      '{'{FUNC_RELEASE, 32'h0, 32'h5000}, 1'b1,
        '{STATUS_OK, 32'h0, 32'h5000, 21'hFFFFF, 1'b0}},
      '{'{FUNC_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1, '0},
      '{'{FUNC_RELEASE, 32'h0, 32'hFFFFFFFF}, 1'b1,
        '{STATUS_NOT_FOUND, 32'h0, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_RELEASE, 32'h0, 32'h2000}, 1'b0, '0},
      '{'{FUNC_RELEASE, 32'h0, 32'h3000}, 1'b0, '0},
      '{'{FUNC_RELEASE, 32'h0, 32'h4000}, 1'b0, '0},
      '{'{FUNC_ALLOC, 32'h10, 32'h0}, 1'b1, '{STATUS_OK, 32'h0, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_RELEASE, 32'h0, 32'h0}, 1'b1, '{STATUS_OK, 32'h0, 32'h0, 21'h1, 1'b0}},
      '{'{FUNC_RELEASE, 32'h0, 32'h0}, 1'b1,
        '{STATUS_NOT_FOUND, 32'h0, 32'h0, 21'h0, 1'b0}},
      '{'{FUNC_ALLOC, 32'h0, 32'h0}, 1'b0, '0}
   };

   virtual_region_allocator_top uut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_item,
      .rsp_valid,
      .rsp_item,
      .psel,
      .penable,
      .pwrite,
      .paddr,
      .pwdata,
      .prdata,
      .pready
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void reset_table();
      region_base_q[0] = pool_base_q;
      region_size_q[0] = ONE_PAGE;
      region_total = 1;
   endfunction

   function automatic rsp_type allocator_outcome(req_type r);
      rsp_type     o;
      logic [63:0] pages;
      logic [32:0] upper;
      int unsigned i;
      o = '0;
      case (r.func)
         FUNC_ALLOC: begin
            if (region_total >= REGIONS) begin
               o.status = STATUS_FULL;
            end else begin
               pages = ({32'b0, r.request_size} + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
               if (region_total == 0) begin
                  o.region_address = pool_base_q;
               end else begin
                  o.region_address = region_base_q[region_total - 1]
                                   + region_size_q[region_total - 1];
               end
               region_base_q[region_total] = o.region_address;
               region_size_q[region_total] = 32'(pages * 64'(PAGE_BYTES));
               region_total++;
            end
         end
         FUNC_RELEASE: begin
            i = 0;
            while (i < region_total && region_base_q[i] != r.address) i++;
            if (i >= region_total) begin
               o.status = STATUS_NOT_FOUND;
            end else begin
               o.free_start = r.address;
               o.free_pages = FREE_PAGES_W'(region_size_q[i] / ONE_PAGE);
               while (i + 1 < region_total) begin
                  region_base_q[i] = region_base_q[i + 1];
                  region_size_q[i] = region_size_q[i + 1];
                  i++;
               end
               region_total--;
            end
         end
         FUNC_CHECK: begin
            upper = {1'b0, pool_base_q} + {1'b0, pool_size_q};
            o.legitimate = (r.address >= pool_base_q) && ({1'b0, r.address} <= upper);
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(99);
      if (roll < 45) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic req_type random_item(int alloc_pct);
      req_type r;
      int      roll;
      int      span;
      r.func = FUNC_UNUSED;
      r.request_size = $urandom;
      r.address = $urandom;
      roll = $urandom_range(99);
      span = 100 - alloc_pct;
      if (roll < alloc_pct) begin
         r.func = FUNC_ALLOC;
         case ($urandom_range(9))
            0: r.request_size = 32'hFFFFFFFF;
            1: r.request_size = '0;
            2: begin
            end
            default: r.request_size = $urandom_range(5 * PAGE_BYTES);
         endcase
      end else if (roll - alloc_pct < span * 60 / 100) begin
         r.func = FUNC_RELEASE;
         if (region_total > 0 && $urandom_range(9) < 8) begin
            r.address = region_base_q[$urandom_range(region_total - 1)];
         end else if ($urandom_range(1) == 0) begin
            r.address = pool_base_q;
         end
      end else if (roll - alloc_pct < span * 95 / 100) begin
         r.func = FUNC_CHECK;
         case ($urandom_range(5))
            0: r.address = pool_base_q;
            1: r.address = pool_base_q - 32'd1;
            2: r.address = pool_base_q + pool_size_q;
            3: r.address = pool_base_q + pool_size_q + 32'd1;
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      predicted = allocator_outcome(item);
      expected_rsps.push_back(typed ? want : predicted);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] where, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= where;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (where == ADDR_POOL_BASE) begin
         pool_base_q = value;
         reset_table();
      end else begin
         pool_size_q = value;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("transfer with no result pending", rsp_item.region_address, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
            if (rsp_item.region_address !== want.region_address)
               report_mismatch("region_address", rsp_item.region_address, want.region_address);
            if (rsp_item.free_start !== want.free_start)
               report_mismatch("free_start", rsp_item.free_start, want.free_start);
            if (rsp_item.free_pages !== want.free_pages)
               report_mismatch("free_pages", 32'(rsp_item.free_pages), 32'(want.free_pages));
            if (rsp_item.legitimate !== want.legitimate)
               report_mismatch("legitimate", 32'(rsp_item.legitimate), 32'(want.legitimate));
         end
      end
   end

   initial begin
      req_type     item;
      logic [31:0] base_value;
      logic [31:0] size_value;
      int          alloc_pct;
      start = 1'b0;
      req_item = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      errors = 0;
      quiet = 1'b0;
      pool_base_q = '0;
      pool_size_q = '0;
      reset_table();
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         send_item(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);

      for (int phase = 0; phase < 12; phase++) begin
         drain();
         repeat (4) @(posedge clock);
         case (phase)
            0: begin
               base_value = 32'hFFFFF000;
               size_value = 32'hFFFFFFFF;
            end
            1: begin
               base_value = 32'hFFFFFFFF;
               size_value = '0;
            end
            2: begin
               base_value = '0;
               size_value = 32'hFFFFFFFF;
            end
            default: begin
               base_value = $urandom & PAGE_MASK;
               size_value = ($urandom_range(1) == 0) ? $urandom
                                                     : $urandom_range(64 * PAGE_BYTES);
            end
         endcase
         csr_write(ADDR_POOL_SIZE, size_value);
         // some phases keep the region table from the phase before
         if (phase % 4 != 3) csr_write(ADDR_POOL_BASE, base_value);
         quiet = (phase % 4 == 2);
         alloc_pct = (phase % 3 == 0) ? 70 : (phase % 3 == 1) ? 45 : 25;
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(199) == 0) drain();
            item = random_item(alloc_pct);
            send_item(item, 1'b0, '0);
         end
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
